// ----- hdl/rms_dynamic_range_compressor_unit_assert.svh -----
// Assertion macros for the RMS compressor unit.
// Included by the top level; relies on i_clk and i_rst_n in the including scope.
`ifndef RMS_DYNAMIC_RANGE_COMPRESSOR_UNIT_ASSERT_SVH
`define RMS_DYNAMIC_RANGE_COMPRESSOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RDRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RDRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rdrc_pkg.sv -----
// Shared types, constants and constant tables of the RMS compressor unit.
// No dependencies; used by the sequencer, the datapath and the top level.
package rdrc_pkg;

    localparam int LOG_TABLE_ENTRIES = 64;
    localparam int EXP_TABLE_ENTRIES = 64;

    localparam int LOG_IDX_W = $clog2(LOG_TABLE_ENTRIES + 1);
    localparam int EXP_IDX_W = $clog2(EXP_TABLE_ENTRIES + 1);
    localparam int LFN_W     = 32 + $clog2(LOG_TABLE_ENTRIES);
    localparam int EFN_W     = 17 + $clog2(EXP_TABLE_ENTRIES);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [31:0] DB10_PER_LOG2_Q24 = 32'd50504453;
    localparam logic [31:0] LOG2_10_DIV20_Q24 = 32'd2786635;
    localparam logic signed [17:0] FLOOR_LEVEL_Q8 = -18'sd61440;

    localparam logic signed [15:0] THRESHOLD_RST = -16'sd5120;
    localparam logic [15:0]        SLOPE_RST     = 16'd49152;
    localparam logic signed [13:0] MAKEUP_RST    = 14'sd0;
    localparam logic [23:0]        ATTACK_RST    = 24'd16742302;
    localparam logic [23:0]        RELEASE_RST   = 24'd16773721;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_SLOPE     = 3'd1,
        CFG_MAKEUP    = 3'd2,
        CFG_ATTACK    = 3'd3,
        CFG_RELEASE   = 3'd4
    } t_cfg_idx;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_SQ, OP_MS1, OP_MS2, OP_MS3, OP_NRM, OP_LOG1, OP_LOG2,
        OP_LVL, OP_EXC, OP_RED, OP_TOT, OP_EXP0, OP_EXP1, OP_EXP2, OP_EXP3,
        OP_NUM, OP_MAG, OP_STORE
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [4:0] nrm_amt;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    typedef logic [LOG_TABLE_ENTRIES:0][31:0] t_log_rom;
    typedef logic [EXP_TABLE_ENTRIES:0][31:0] t_exp_rom;

    function automatic logic [63:0] isqrt64(input logic [63:0] vin);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        int i;
        v = vin;
        r = 64'd0;
        b = 64'd1 << 62;
        for (i = 0; i < 32; i++) begin
            if (b > v) b = b >> 2;
        end
        for (i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] log2_q16(input logic [63:0] xin);
        logic [63:0] x;
        logic [31:0] r;
        int i;
        x = xin;
        r = 32'd0;
        if (x >= (64'd1 << 31)) return 32'd65536;
        for (i = 0; i < 17; i++) begin
            x = (x * x) >> 30;
            r = r << 1;
            if (x >= (64'd1 << 31)) begin
                x = x >> 1;
                r = r | 32'd1;
            end
        end
        return (r + 32'd1) >> 1;
    endfunction

    function automatic logic [31:0] exp2_q30(input logic [23:0] f);
        logic [63:0] root;
        logic [63:0] p;
        int i;
        root = isqrt64(64'd1 << 61);
        p = 64'd1 << 30;
        for (i = 0; i < 24; i++) begin
            if (f[23-i]) p = (p * root + (64'd1 << 29)) >> 30;
            root = isqrt64(root << 30);
        end
        return p[31:0];
    endfunction

    function automatic t_log_rom build_log_rom();
        t_log_rom rom;
        logic [63:0] x;
        int k;
        for (k = 0; k <= LOG_TABLE_ENTRIES; k++) begin
            x = (64'd1 << 30) + ((64'(k) << 30) / LOG_TABLE_ENTRIES);
            rom[k] = log2_q16(x);
        end
        return rom;
    endfunction

    function automatic t_exp_rom build_exp_rom();
        t_exp_rom rom;
        logic [63:0] f;
        int k;
        for (k = 0; k <= EXP_TABLE_ENTRIES; k++) begin
            f = (64'(k) << 24) / EXP_TABLE_ENTRIES;
            if (k == EXP_TABLE_ENTRIES) rom[k] = 32'd1 << 31;
            else rom[k] = exp2_q30(f[23:0]);
        end
        return rom;
    endfunction

    localparam t_log_rom LOG_ROM = build_log_rom();
    localparam t_exp_rom EXP_ROM = build_exp_rom();

endpackage

// ----- hdl/rdrc_in_if.sv -----
// Request channel carrying input samples into the compressor.
// No dependencies.
interface rdrc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

// ----- hdl/rdrc_out_if.sv -----
// Request channel carrying compressed samples out of the compressor.
// No dependencies.
interface rdrc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

// ----- hdl/rdrc_ctrl.sv -----
// Sequencer of the compressor: steps the datapath through one sample.
// Depends on rdrc_pkg.
module rdrc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rdrc_pkg::t_dp_status i_st,
    output rdrc_pkg::t_dp_cmd   o_cmd
);
    import rdrc_pkg::*;

    typedef enum logic [22:0] {
        S_IDLE = 23'd1 << 0,  S_SQ   = 23'd1 << 1,  S_MS1  = 23'd1 << 2,
        S_MS2  = 23'd1 << 3,  S_MS3  = 23'd1 << 4,  S_N16  = 23'd1 << 5,
        S_N8   = 23'd1 << 6,  S_N4   = 23'd1 << 7,  S_N2   = 23'd1 << 8,
        S_N1   = 23'd1 << 9,  S_LOG1 = 23'd1 << 10, S_LOG2 = 23'd1 << 11,
        S_LVL  = 23'd1 << 12, S_EXC  = 23'd1 << 13, S_RED  = 23'd1 << 14,
        S_TOT  = 23'd1 << 15, S_EXP0 = 23'd1 << 16, S_EXP1 = 23'd1 << 17,
        S_EXP2 = 23'd1 << 18, S_EXP3 = 23'd1 << 19, S_NUM  = 23'd1 << 20,
        S_MAG  = 23'd1 << 21, S_OUT  = 23'd1 << 22
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd.op      = OP_NOP;
        o_cmd.nrm_amt = 5'd0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_SQ;
                end
            end
            S_SQ:   begin o_cmd.op = OP_SQ;   n_state = S_MS1; end
            S_MS1:  begin o_cmd.op = OP_MS1;  n_state = S_MS2; end
            S_MS2:  begin o_cmd.op = OP_MS2;  n_state = S_MS3; end
            S_MS3:  begin o_cmd.op = OP_MS3;  n_state = S_N16; end
            S_N16:  begin o_cmd.op = OP_NRM; o_cmd.nrm_amt = 5'd16; n_state = S_N8; end
            S_N8:   begin o_cmd.op = OP_NRM; o_cmd.nrm_amt = 5'd8;  n_state = S_N4; end
            S_N4:   begin o_cmd.op = OP_NRM; o_cmd.nrm_amt = 5'd4;  n_state = S_N2; end
            S_N2:   begin o_cmd.op = OP_NRM; o_cmd.nrm_amt = 5'd2;  n_state = S_N1; end
            S_N1:   begin o_cmd.op = OP_NRM; o_cmd.nrm_amt = 5'd1;  n_state = S_LOG1; end
            S_LOG1: begin o_cmd.op = OP_LOG1; n_state = S_LOG2; end
            S_LOG2: begin o_cmd.op = OP_LOG2; n_state = S_LVL; end
            S_LVL:  begin o_cmd.op = OP_LVL;  n_state = S_EXC; end
            S_EXC:  begin o_cmd.op = OP_EXC;  n_state = S_RED; end
            S_RED:  begin o_cmd.op = OP_RED;  n_state = S_TOT; end
            S_TOT:  begin o_cmd.op = OP_TOT;  n_state = S_EXP0; end
            S_EXP0: begin o_cmd.op = OP_EXP0; n_state = S_EXP1; end
            S_EXP1: begin o_cmd.op = OP_EXP1; n_state = S_EXP2; end
            S_EXP2: begin o_cmd.op = OP_EXP2; n_state = S_EXP3; end
            S_EXP3: begin o_cmd.op = OP_EXP3; n_state = S_NUM; end
            S_NUM:  begin o_cmd.op = OP_NUM;  n_state = S_MAG; end
            S_MAG:  begin o_cmd.op = OP_MAG;  n_state = S_OUT; end
            S_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.op = OP_STORE;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ----- hdl/rdrc_datapath.sv -----
// Datapath of the compressor: registers, shared multiplier, tables and output register.
// Depends on rdrc_pkg.
module rdrc_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [rdrc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rdrc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic signed [15:0]           i_sample,
    input  logic                         i_out_ready,
    input  rdrc_pkg::t_dp_cmd            i_cmd,
    output rdrc_pkg::t_dp_status         o_st,
    output logic                         o_out_valid,
    output logic signed [15:0]           o_sample_out
);
    import rdrc_pkg::*;

    logic signed [15:0] r_thr;
    logic [15:0]        r_slope;
    logic signed [13:0] r_mk;
    logic [23:0]        r_att;
    logic [23:0]        r_rel;

    logic               r_sgn;
    logic [16:0]        r_a;
    logic [30:0]        r_sq;
    logic [23:0]        r_c;
    logic [55:0]        r_acc;
    logic [31:0]        r_ms;
    logic [31:0]        r_norm;
    logic [4:0]         r_sh;
    logic [63:0]        r_prod;
    logic [31:0]        r_lbase;
    logic [20:0]        r_neg;
    logic [16:0]        r_exc;
    logic signed [18:0] r_tot;
    logic signed [7:0]  r_ip;
    logic [EXP_IDX_W-1:0] r_eidx;
    logic [15:0]        r_erem;
    logic [31:0]        r_ebase;
    logic [31:0]        r_mant;
    logic [47:0]        r_num;
    logic [14:0]        r_mag;
    logic               r_out_vld;
    logic signed [15:0] r_out;

    logic [31:0] m_a;
    logic [31:0] m_b;
    logic [63:0] m_p;

    logic [16:0]          a_in;
    logic [23:0]          coef;
    logic [24:0]          coef_c;
    logic [LFN_W-1:0]     lfn;
    logic [LOG_IDX_W-1:0] lidx;
    logic [LOG_IDX_W-1:0] lidx1;
    logic [31:0]          ldiff;
    logic [31:0]          lf;
    logic signed [23:0]   negv;
    logic [31:0]          q;
    logic signed [18:0]   lvl;
    logic signed [18:0]   exv;
    logic [16:0]          red;
    logic [18:0]          tot_abs;
    logic signed [63:0]   sp;
    logic signed [63:0]   ev;
    logic [EFN_W-1:0]     efn;
    logic [EXP_IDX_W-1:0] eidx1;
    logic [31:0]          ediff;
    logic signed [8:0]    shs;
    logic [5:0]           sh;
    logic [62:0]          scaled;
    logic [14:0]          mag;
    logic [5:0]           nrm_top;
    logic                 nrm_hit;

    assign o_st.out_free = !r_out_vld || i_out_ready;
    assign o_out_valid   = r_out_vld;
    assign o_sample_out  = r_out;

    always_comb begin
        a_in    = i_sample[15] ? 17'(-{i_sample[15], i_sample}) : {1'b0, i_sample};
        coef    = ({1'b0, r_sq} > r_ms) ? r_att : r_rel;
        coef_c  = 25'd1 << 24;
        coef_c  = coef_c - {1'b0, r_c};
        nrm_top = 6'd32 - {1'b0, i_cmd.nrm_amt};
        nrm_hit = ((r_norm >> nrm_top) == 32'd0);

        lfn   = LFN_W'(r_norm[30:0]) * LFN_W'(LOG_TABLE_ENTRIES);
        lidx  = LOG_IDX_W'(lfn >> 31);
        lidx1 = lidx + LOG_IDX_W'(1);
        ldiff = LOG_ROM[lidx1] - LOG_ROM[lidx];

        lf   = r_lbase + 32'((r_prod + (64'd1 << 30)) >> 31);
        negv = 24'({r_sh, 16'd0}) - 24'sd65536 - 24'(lf);

        q   = 32'((r_prod + (64'd1 << 31)) >> 32);
        lvl = (r_ms == 32'd0) ? 19'(FLOOR_LEVEL_Q8) : -$signed({2'b00, q[16:0]});
        exv = lvl - 19'(r_thr);

        red = 17'((r_prod + 64'd32768) >> 16);
        tot_abs = r_tot[18] ? 19'(-r_tot) : 19'(r_tot);

        sp  = r_tot[18] ? -$signed(r_prod) : $signed(r_prod);
        ev  = (sp + 64'sd32768) >>> 16;
        efn = EFN_W'(ev[15:0]) * EFN_W'(EXP_TABLE_ENTRIES);
        eidx1 = r_eidx + EXP_IDX_W'(1);
        ediff = EXP_ROM[eidx1] - EXP_ROM[r_eidx];

        shs    = 9'sd45 - 9'(r_ip);
        sh     = shs[5:0];
        scaled = ({15'd0, r_num} << 15) - {15'd0, r_num};
        if (shs >= 9'sd62) begin
            mag = 15'd0;
        end else if ((r_num >> sh) != 48'd0) begin
            mag = 15'd32767;
        end else begin
            mag = 15'(scaled >> sh);
        end

        m_a = 32'd0;
        m_b = 32'd0;
        case (i_cmd.op)
            OP_SQ:   begin m_a = 32'(r_a);     m_b = 32'(r_a); end
            OP_MS1:  begin m_a = 32'(coef);    m_b = r_ms; end
            OP_MS2:  begin m_a = 32'(coef_c);  m_b = 32'(r_sq); end
            OP_LOG1: begin m_a = ldiff;        m_b = 32'(lfn[30:0]); end
            OP_LVL:  begin m_a = 32'(r_neg);   m_b = DB10_PER_LOG2_Q24; end
            OP_RED:  begin m_a = 32'(r_exc);   m_b = 32'(r_slope); end
            OP_EXP0: begin m_a = 32'(tot_abs); m_b = LOG2_10_DIV20_Q24; end
            OP_EXP2: begin m_a = ediff;        m_b = 32'(r_erem); end
            OP_NUM:  begin m_a = 32'(r_a);     m_b = r_mant; end
            default: begin m_a = 32'd0;        m_b = 32'd0; end
        endcase
        m_p = {32'd0, m_a} * {32'd0, m_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= THRESHOLD_RST;
            r_slope   <= SLOPE_RST;
            r_mk      <= MAKEUP_RST;
            r_att     <= ATTACK_RST;
            r_rel     <= RELEASE_RST;
            r_ms      <= 32'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_THRESHOLD: r_thr   <= i_cfg_data[15:0];
                    CFG_SLOPE:     r_slope <= i_cfg_data[15:0];
                    CFG_MAKEUP:    r_mk    <= i_cfg_data[13:0];
                    CFG_ATTACK:    r_att   <= i_cfg_data;
                    CFG_RELEASE:   r_rel   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_STORE) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.op == OP_MS3) begin
                r_ms <= r_acc[55:24];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_sgn <= i_sample[15];
                r_a   <= a_in;
            end
            OP_SQ:   r_sq <= m_p[30:0];
            OP_MS1: begin
                r_c   <= coef;
                r_acc <= m_p[55:0];
            end
            OP_MS2:  r_acc <= r_acc + m_p[55:0] + (56'd1 << 23);
            OP_MS3: begin
                r_norm <= r_acc[55:24];
                r_sh   <= 5'd0;
            end
            OP_NRM: begin
                if (nrm_hit) begin
                    r_norm <= r_norm << i_cmd.nrm_amt;
                    r_sh   <= r_sh + i_cmd.nrm_amt;
                end
            end
            OP_LOG1: begin
                r_prod  <= m_p;
                r_lbase <= LOG_ROM[lidx];
            end
            OP_LOG2: r_neg <= negv[23] ? 21'd0 : negv[20:0];
            OP_LVL:  r_prod <= m_p;
            OP_EXC:  r_exc <= exv[18] ? 17'd0 : exv[16:0];
            OP_RED:  r_prod <= m_p;
            OP_TOT:  r_tot <= 19'(r_mk) - $signed({2'b00, red});
            OP_EXP0: r_prod <= m_p;
            OP_EXP1: begin
                r_ip   <= 8'(ev >>> 16);
                r_eidx <= EXP_IDX_W'(efn >> 16);
                r_erem <= efn[15:0];
            end
            OP_EXP2: begin
                r_prod  <= m_p;
                r_ebase <= EXP_ROM[r_eidx];
            end
            OP_EXP3: r_mant <= r_ebase + 32'((r_prod + 64'd32768) >> 16);
            OP_NUM:  r_num <= m_p[47:0];
            OP_MAG:  r_mag <= mag;
            OP_STORE: r_out <= r_sgn ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
            default: ;
        endcase
    end
endmodule

// ----- hdl/rms_dynamic_range_compressor_unit.sv -----
// Top level of the RMS compressor: sequencer, datapath and assertions.
// Depends on rdrc_pkg, rdrc_in_if, rdrc_out_if, rdrc_ctrl, rdrc_datapath and the assert header.
// Each accepted sample has its result stored in the output register after the sequencer
// steps a single 32 by 32 multiplier through the level update, the log and exponential
// table interpolations and the final gain product, with five normalization steps for the
// level in between. A new sample is accepted only once the previous result has been stored,
// and storing waits while the output register holds a result that the sink has not taken.
`include "rms_dynamic_range_compressor_unit_assert.svh"
module rms_dynamic_range_compressor_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rdrc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rdrc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rdrc_in_if.sink                         i_in,
    rdrc_out_if.source                      o_out
);
    import rdrc_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_st;
    logic       in_ready;

    assign i_in.ready = in_ready;

    rdrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_st       (dp_st),
        .o_cmd      (dp_cmd)
    );

    rdrc_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample     (i_in.sample_in),
        .i_out_ready  (o_out.ready),
        .i_cmd        (dp_cmd),
        .o_st         (dp_st),
        .o_out_valid  (o_out.valid),
        .o_sample_out (o_out.sample_out)
    );

    `RDRC_ASSERT_NEXT(a_busy_after_accept, i_in.valid && in_ready, !in_ready, "accepted twice")
    `RDRC_ASSERT_NOW(a_idle_ops, in_ready, dp_cmd.op == OP_NOP || dp_cmd.op == OP_LOAD, "op in idle")
    `RDRC_ASSERT_NOW(a_out_from_store, $rose(o_out.valid), $past(dp_cmd.op == OP_STORE), "no store")
endmodule
